// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define KNN_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after the trigger.
`define KNN_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Types, codes and default sizes shared by the nearest-neighbor vote block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package knn_pkg;

    // Default sizes.
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_MAX_K       = 16;
    localparam int DEF_MAX_CLASSES = 16;
    localparam int DEF_DIST_BITS   = 32;

    // Fixed field widths.
    localparam int CLASS_W    = 4;
    localparam int VOTES_W    = 5;
    localparam int COUNT_W    = 32;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 5;

    localparam int OUT_FIELDS_W = CLASS_W + VOTES_W + 1 + 2 * COUNT_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_NEIGHBOUR_COUNT = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_CLASS_COUNT     = CFG_ADDR_W'(1);

    localparam logic [CFG_DATA_W-1:0] NEIGHBOUR_COUNT_RST = CFG_DATA_W'(1);
    localparam logic [CFG_DATA_W-1:0] CLASS_COUNT_RST     = CFG_DATA_W'(2);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SCAN,
        ST_SETTLE,
        ST_VOTE_RD,
        ST_VOTE_WR,
        ST_DONE
    } knn_state_t;

    // Strobes from the sequencer to the scan unit.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic init;
        logic commit;
    } scan_ctrl_t;

endpackage

// File: rtl/knn_scan.sv
// ----------------------------------------------------------------------------
// knn_scan
// Candidate memory with a registered read, and the nearest-candidate search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module knn_scan
    import knn_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_K       = DEF_MAX_K,
    parameter int DIST_BITS   = DEF_DIST_BITS,
    localparam int AW  = $clog2(MAX_ENTRIES),
    localparam int KCW = $clog2(MAX_K + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  scan_ctrl_t           ctrl,
    input  logic [AW-1:0]        wr_addr,
    input  logic [DIST_BITS-1:0] wr_dist,
    input  logic [CLASS_W-1:0]   wr_cls,
    input  logic [AW-1:0]        rd_addr,
    input  logic [KCW-1:0]       scan_idx,
    output logic [CLASS_W-1:0]   pick_cls
);

    localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int MW  = DIST_BITS + CLASS_W;

    logic [MW-1:0]        mem_reg [MAX_ENTRIES];
    logic [MW-1:0]        rd_data_reg;
    logic                 cmp_vld_reg;
    logic [AW-1:0]        cmp_idx_reg;
    logic [AW-1:0]        chosen_reg [MAX_K];
    logic [DIST_BITS-1:0] best_reg;
    logic [AW-1:0]        pick_reg;
    logic [CLASS_W-1:0]   pick_cls_reg;
    logic [CLASS_W-1:0]   class0_reg;
    logic                 taken;
    logic                 better;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem_reg[wr_addr] <= {wr_cls, wr_dist};
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
            cmp_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= ctrl.rd_en;
        end
    end

    // An entry taken by an earlier scan of this query is skipped.
    always_comb
    begin
        taken = 1'b0;
        for (int l = 0; l < MAX_K; l++)
        begin
            if ((KCW'(l) < scan_idx) && (chosen_reg[l] == cmp_idx_reg))
            begin
                taken = 1'b1;
            end
        end
    end

    assign better = cmp_vld_reg && (rd_data_reg[DIST_BITS-1:0] < best_reg) && !taken;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && (wr_addr == '0))
        begin
            class0_reg <= wr_cls;
        end
        if (ctrl.init)
        begin
            best_reg     <= '1;
            pick_reg     <= '0;
            pick_cls_reg <= class0_reg;
        end
        else if (better)
        begin
            best_reg     <= rd_data_reg[DIST_BITS-1:0];
            pick_reg     <= cmp_idx_reg;
            pick_cls_reg <= rd_data_reg[MW-1:DIST_BITS];
        end
        if (ctrl.commit)
        begin
            chosen_reg[scan_idx[KIW-1:0]] <= pick_reg;
        end
    end

    assign pick_cls = pick_cls_reg;

endmodule

// File: rtl/knn_vote_classifier.sv
// ----------------------------------------------------------------------------
// knn_vote_classifier
// k-nearest-neighbor majority vote over one query's candidate distances.
// ----------------------------------------------------------------------------
// Candidates are taken at one transfer per cycle while loading; only the last
// item of a query produces a result. From that last transfer the result is
// built by the vote memory clear, k scans over the n stored entries, and the
// result load; s_tready stays low meanwhile, so the scans set the rate. Reset
// clears the counters, the sequencer and the output valid; the memories are
// written before they are read.
`timescale 1ns / 1ps

module knn_vote_classifier
    import knn_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_K       = DEF_MAX_K,
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int DIST_BITS   = DEF_DIST_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Candidate stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: distance_value, neighbour_class, query_class, zero fill.
    input  logic [((DIST_BITS + 2 * CLASS_W + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                  s_tlast,   // last_entry

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: predicted_class, winning_votes, mismatch, error_total,
    // query_total, zero fill.
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int KCW = $clog2(MAX_K + 1);
    localparam int VW  = $clog2(MAX_K + 1);
    localparam int CIW = $clog2(MAX_CLASSES);
    localparam int NCW = $clog2(MAX_CLASSES + 1);

    // ------------------------------------------------------------------------
    // Configuration registers. The port never stalls.
    // ------------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] neighbour_count_reg;
    logic [CFG_DATA_W-1:0] class_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neighbour_count_reg <= NEIGHBOUR_COUNT_RST;
            class_count_reg     <= CLASS_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                REG_NEIGHBOUR_COUNT: neighbour_count_reg <= cfg_data;
                REG_CLASS_COUNT:     class_count_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Effective k and class count, clipped to what the hardware holds.
    logic [KCW-1:0] k_eff;
    logic [NCW-1:0] nclass_eff;

    always_comb
    begin
        k_eff = (32'(neighbour_count_reg) > 32'(MAX_K)) ? KCW'(MAX_K)
                                                        : KCW'(neighbour_count_reg);
        if (class_count_reg == '0)
        begin
            nclass_eff = NCW'(1);
        end
        else if (32'(class_count_reg) > 32'(MAX_CLASSES))
        begin
            nclass_eff = NCW'(MAX_CLASSES);
        end
        else
        begin
            nclass_eff = NCW'(class_count_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Input fields.
    // ------------------------------------------------------------------------
    logic [DIST_BITS-1:0] in_dist;
    logic [CLASS_W-1:0]   in_ncls;
    logic [CLASS_W-1:0]   in_qcls;
    logic                 in_fire;

    assign in_dist = s_tdata[DIST_BITS-1:0];
    assign in_ncls = s_tdata[DIST_BITS + CLASS_W - 1:DIST_BITS];
    assign in_qcls = s_tdata[DIST_BITS + 2 * CLASS_W - 1:DIST_BITS + CLASS_W];
    assign in_fire = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Sequencer state and datapath registers.
    // ------------------------------------------------------------------------
    knn_state_t           state_reg, state_next;
    scan_ctrl_t           scan_ctrl;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        n_reg;
    logic [CW-1:0]        rd_addr_reg;
    logic [CIW-1:0]       clr_addr_reg;
    logic [KCW-1:0]       scan_reg;
    logic [CLASS_W-1:0]   qcls_reg;
    logic [CLASS_W-1:0]   pick_cls;
    logic [CIW-1:0]       vote_idx_reg;
    logic [VW-1:0]        vote_rd_reg;
    logic [VW-1:0]        vote_inc;
    logic [CIW-1:0]       best_cls_reg;
    logic [VW-1:0]        best_votes_reg;
    logic [VW-1:0]        vote_mem_reg [MAX_CLASSES];
    logic                 vote_we;
    logic [CIW-1:0]       vote_waddr;
    logic [VW-1:0]        vote_wdata;
    logic [CIW-1:0]       pick_idx;
    logic                 out_load;
    logic                 miss;
    logic                 store_ok;

    logic                 m_valid_reg;
    logic [CLASS_W-1:0]   out_cls_reg;
    logic [VOTES_W-1:0]   out_votes_reg;
    logic                 out_miss_reg;
    logic [COUNT_W-1:0]   error_reg;
    logic [COUNT_W-1:0]   query_reg;

    // Items past the memory depth are neither stored nor counted.
    assign store_ok = (32'(count_reg) < 32'(MAX_ENTRIES));

    // Out-of-range neighbor classes vote for class 0.
    assign pick_idx = (32'(pick_cls) >= 32'(nclass_eff)) ? '0 : CIW'(pick_cls);
    assign vote_inc = vote_rd_reg + VW'(1);
    assign miss     = (32'(best_cls_reg) != 32'(qcls_reg));

    // Next state and strobes.
    always_comb
    begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        scan_ctrl.wr_en  = 1'b0;
        scan_ctrl.rd_en  = 1'b0;
        scan_ctrl.init   = 1'b0;
        scan_ctrl.commit = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready        = 1'b1;
                scan_ctrl.wr_en = s_tvalid && store_ok;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (32'(clr_addr_reg) == 32'(MAX_CLASSES - 1))
                begin
                    scan_ctrl.init = 1'b1;
                    state_next     = (k_eff == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_ctrl.rd_en = 1'b1;
                if (rd_addr_reg == n_reg - CW'(1))
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_VOTE_RD;
            end
            ST_VOTE_RD:
            begin
                scan_ctrl.commit = 1'b1;
                state_next       = ST_VOTE_WR;
            end
            ST_VOTE_WR:
            begin
                if (scan_reg + KCW'(1) == k_eff)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_ctrl.init = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                if (s_tlast)
                begin
                    count_reg <= '0;
                end
                else if (store_ok)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    // Per-query registers. The vote memory is read in ST_VOTE_RD and written in
    // ST_VOTE_WR, and the next read of it comes after the write, so its
    // read-modify-write never overlaps.
    always_ff @(posedge clk)
    begin
        if (in_fire && s_tlast)
        begin
            n_reg          <= store_ok ? count_reg + CW'(1) : count_reg;
            qcls_reg       <= in_qcls;
            clr_addr_reg   <= '0;
            scan_reg       <= '0;
            best_cls_reg   <= '0;
            best_votes_reg <= '0;
        end
        if (state_reg == ST_CLEAR)
        begin
            clr_addr_reg <= clr_addr_reg + CIW'(1);
        end
        if (scan_ctrl.init)
        begin
            rd_addr_reg <= '0;
        end
        else if (scan_ctrl.rd_en)
        begin
            rd_addr_reg <= rd_addr_reg + CW'(1);
        end
        if (state_reg == ST_VOTE_RD)
        begin
            vote_rd_reg  <= vote_mem_reg[pick_idx];
            vote_idx_reg <= pick_idx;
        end
        if (state_reg == ST_VOTE_WR)
        begin
            scan_reg <= scan_reg + KCW'(1);
            // Counts only grow, so keeping the leader on each increment,
            // lower class first on a tie, gives the earliest class with the
            // most votes at the end.
            if ((vote_inc > best_votes_reg)
                || ((vote_inc == best_votes_reg) && (vote_idx_reg < best_cls_reg)))
            begin
                best_votes_reg <= vote_inc;
                best_cls_reg   <= vote_idx_reg;
            end
        end
    end

    // Vote memory: one write port shared by the clearing sweep and the votes.
    always_comb
    begin
        vote_we    = (state_reg == ST_CLEAR) || (state_reg == ST_VOTE_WR);
        vote_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : vote_idx_reg;
        vote_wdata = (state_reg == ST_CLEAR) ? '0 : vote_inc;
    end

    always_ff @(posedge clk)
    begin
        if (vote_we)
        begin
            vote_mem_reg[vote_waddr] <= vote_wdata;
        end
    end

    // ------------------------------------------------------------------------
    // Candidate memory and the scan compare.
    // ------------------------------------------------------------------------
    knn_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_K       (MAX_K),
        .DIST_BITS   (DIST_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .wr_addr  (count_reg[AW-1:0]),
        .wr_dist  (in_dist),
        .wr_cls   (in_ncls),
        .rd_addr  (rd_addr_reg[AW-1:0]),
        .scan_idx (scan_reg),
        .pick_cls (pick_cls)
    );

    // ------------------------------------------------------------------------
    // Output register and running counters. A finished result waits here so
    // that the next query can load while it is pending.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            error_reg   <= '0;
            query_reg   <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                if (miss && (error_reg != '1))
                begin
                    error_reg <= error_reg + COUNT_W'(1);
                end
                if (query_reg != '1)
                begin
                    query_reg <= query_reg + COUNT_W'(1);
                end
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cls_reg   <= CLASS_W'(best_cls_reg);
            out_votes_reg <= VOTES_W'(best_votes_reg);
            out_miss_reg  <= miss;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({query_reg, error_reg, out_miss_reg, out_votes_reg, out_cls_reg});

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
`include "assert_macros.svh"

    `KNN_ASSERT_ALWAYS(a_count_bound, (32'(count_reg) <= 32'(MAX_ENTRIES)), "entry count past depth")
    `KNN_ASSERT_ALWAYS(a_scan_addr, (!scan_ctrl.rd_en || (rd_addr_reg < n_reg)), "scan past entries")
    `KNN_ASSERT_ALWAYS(a_votes_bound, ((state_reg == ST_LOAD) || (32'(best_votes_reg) <= 32'(scan_reg))), "votes exceed scans")
    `KNN_ASSERT_NEXT(a_query_count, out_load, ((query_reg == $past(query_reg) + COUNT_W'(1)) || ($past(query_reg) == '1)), "query count not advanced")

endmodule

// File: verif/tb_knn_vote_classifier.sv
// ----------------------------------------------------------------------------
// tb_knn_vote_classifier
// Self-checking bench for the nearest-neighbor vote block. It streams queries
// of candidates, predicts each vote result in a scoreboard, and compares every
// result transfer field by field, under several sender and receiver stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_knn_vote_classifier;
    import knn_pkg::*;

    localparam int DIST_W          = DEF_DIST_BITS;
    localparam int IN_W            = ((DIST_W + 2 * CLASS_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int SETTLE_CYCLES   = 32;
    localparam int TAIL_CYCLES     = 50;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int NUM_PHASES      = 8;

    // Result field positions inside m_tdata, lowest first.
    localparam int VOTES_LSB = CLASS_W;
    localparam int MISS_BIT  = VOTES_LSB + VOTES_W;
    localparam int ERR_LSB   = MISS_BIT + 1;
    localparam int QRY_LSB   = ERR_LSB + COUNT_W;

    // An index that names no register; a write to it must change nothing.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = '1;
    // The all-ones distance marks the query itself.
    localparam logic [DIST_W-1:0]     DIST_SELF  = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [CLASS_W-1:0] predicted_class;
        logic [VOTES_W-1:0] winning_votes;
        logic               mismatch;
        logic [COUNT_W-1:0] error_total;
        logic [COUNT_W-1:0] query_total;
    } vote_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the candidate store, the settings and
    // the running counters, and queues the vote result each query must give.
    // ------------------------------------------------------------------------
    class vote_scoreboard;
        logic [DIST_W-1:0]     dist_mem [DEF_MAX_ENTRIES];
        logic [CLASS_W-1:0]    class_mem[DEF_MAX_ENTRIES];
        int unsigned           stored;
        logic [CFG_DATA_W-1:0] k_setting;
        logic [CFG_DATA_W-1:0] class_setting;
        logic [COUNT_W-1:0]    errors_seen;
        logic [COUNT_W-1:0]    queries_seen;
        vote_result_t          pending_votes[$];
        int unsigned           fail_count;
        int unsigned           results_checked;

        function new();
            stored          = 0;
            k_setting       = NEIGHBOUR_COUNT_RST;
            class_setting   = CLASS_COUNT_RST;
            errors_seen     = '0;
            queries_seen    = '0;
            fail_count      = 0;
            results_checked = 0;
        endfunction

        function int unsigned pending();
            return pending_votes.size();
        endfunction

        function void write_reg(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
            if (addr == REG_NEIGHBOUR_COUNT)
                k_setting = data;
            else if (addr == REG_CLASS_COUNT)
                class_setting = data;
        endfunction

        // Stores one candidate; on the last one of a query, runs the k scans
        // and the vote and queues the expected result.
        function void note_candidate(input logic [IN_W-1:0] data, input logic last);
            logic [DIST_W-1:0]          cand_dist;
            logic [CLASS_W-1:0]         ncls;
            logic [CLASS_W-1:0]         qcls;
            logic [DIST_W-1:0]          best;
            logic [DEF_MAX_ENTRIES-1:0] taken;
            int unsigned                votes[DEF_MAX_CLASSES];
            int unsigned                k;
            int unsigned                nclass;
            int unsigned                pick;
            int unsigned                cls;
            int unsigned                best_cls;
            int unsigned                best_votes;
            vote_result_t               res;

            cand_dist = data[DIST_W-1:0];
            ncls      = data[DIST_W +: CLASS_W];
            qcls      = data[DIST_W + CLASS_W +: CLASS_W];

            // Candidates past the end of the store are dropped.
            if (stored < DEF_MAX_ENTRIES) begin
                dist_mem[stored]  = cand_dist;
                class_mem[stored] = ncls;
                stored++;
            end
            if (!last)
                return;

            k      = (k_setting > DEF_MAX_K) ? DEF_MAX_K : k_setting;
            nclass = (class_setting == 0) ? 1 :
                     ((class_setting > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : class_setting);

            foreach (votes[c])
                votes[c] = 0;
            taken = '0;

            // Each scan takes the first strictly nearer entry not yet taken;
            // a scan that finds nothing falls back to entry 0.
            for (int i = 0; i < k; i++) begin
                best = '1;
                pick = 0;
                for (int j = 0; j < stored; j++) begin
                    if (dist_mem[j] < best && !taken[j]) begin
                        best = dist_mem[j];
                        pick = j;
                    end
                end
                taken[pick] = 1'b1;
                cls = class_mem[pick];
                if (cls >= nclass)
                    cls = 0;
                votes[cls]++;
            end

            best_cls   = 0;
            best_votes = votes[0];
            for (int j = 1; j < nclass; j++) begin
                if (votes[j] > best_votes) begin
                    best_votes = votes[j];
                    best_cls   = j;
                end
            end

            res.predicted_class = best_cls[CLASS_W-1:0];
            res.winning_votes   = best_votes[VOTES_W-1:0];
            res.mismatch        = (best_cls != qcls);
            if (res.mismatch && errors_seen != '1)
                errors_seen++;
            if (queries_seen != '1)
                queries_seen++;
            res.error_total = errors_seen;
            res.query_total = queries_seen;
            pending_votes = {pending_votes, res};
            stored = 0;
        endfunction

        task report(input string what, input logic [COUNT_W-1:0] got,
                    input logic [COUNT_W-1:0] want);
            $display("ERROR result %0d: %s = %0d, expected %0d",
                     results_checked, what, got, want);
            fail_count++;
        endtask

        task check_result(input logic [OUT_W-1:0] data);
            vote_result_t want;

            results_checked++;
            if (pending_votes.size() == 0) begin
                report("unexpected result, query_total", data[QRY_LSB +: COUNT_W], 0);
                return;
            end
            want = pending_votes.pop_front();
            if (data[CLASS_W-1:0] !== want.predicted_class)
                report("predicted_class", data[CLASS_W-1:0], want.predicted_class);
            if (data[VOTES_LSB +: VOTES_W] !== want.winning_votes)
                report("winning_votes", data[VOTES_LSB +: VOTES_W], want.winning_votes);
            if (data[MISS_BIT] !== want.mismatch)
                report("mismatch", data[MISS_BIT], want.mismatch);
            if (data[ERR_LSB +: COUNT_W] !== want.error_total)
                report("error_total", data[ERR_LSB +: COUNT_W], want.error_total);
            if (data[QRY_LSB +: COUNT_W] !== want.query_total)
                report("query_total", data[QRY_LSB +: COUNT_W], want.query_total);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;

    vote_scoreboard sb = new();

    // Stall mix of the current phase, in percent of cycles.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    knn_vote_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls on its own schedule; one assignment per edge.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every transfer on the three channels is observed here, before the edge
    // updates anything, since all inputs are driven with nonblocking writes.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_addr, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_candidate(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog: the longest correct silence is one full-store query at the
    // largest k, and the limit is set far above it.
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (s_tvalid && s_tready)
                || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("knn_vote_classifier verification failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one candidate, after any idle cycles the sender takes, and
    // returns at the edge of its transfer with tvalid still high.
    task automatic send_candidate(input logic [DIST_W-1:0] cand_dist,
                                  input logic [CLASS_W-1:0] ncls,
                                  input logic [CLASS_W-1:0] qcls,
                                  input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({qcls, ncls, cand_dist});
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // One register write; cfg_valid stays high for a following write.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] k,
                                 input logic [CFG_DATA_W-1:0] nclass);
        write_reg(REG_NEIGHBOUR_COUNT, k);
        write_reg(REG_CLASS_COUNT, nclass);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every query has returned its result, then lets the block
    // settle so that registers are only written while it is idle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One query of random candidates. The distance style varies per query:
    // tight ranges for ties, full range for bit coverage, self marks mixed in,
    // and values next to the all-ones mark.
    task automatic run_query(input int unsigned length);
        int unsigned       style;
        logic [DIST_W-1:0] cand_dist;
        int unsigned       roll;

        style = $urandom_range(3);
        for (int unsigned i = 0; i < length; i++) begin
            roll = $urandom_range(99);
            case (style)
                0: cand_dist = DIST_W'($urandom_range(7));
                1: cand_dist = DIST_W'($urandom());
                2: cand_dist = (roll < 20) ? DIST_SELF :
                               (roll < 30) ? '0 : DIST_W'($urandom_range(255));
                default: cand_dist = DIST_SELF - DIST_W'($urandom_range(15));
            endcase
            send_candidate(cand_dist, CLASS_W'($urandom_range(15)),
                           CLASS_W'($urandom_range(15)), (i == length - 1));
        end
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 64; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            IDLE_BOTH:     begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] phase_k[NUM_PHASES];
        logic [CFG_DATA_W-1:0] phase_cls[NUM_PHASES];
        int unsigned           phase_items;
        int unsigned           length;

        phase_k   = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd0, 5'd0, 5'd8};
        phase_cls = '{5'd16, 5'd1, 5'd17, 5'd3, 5'd31, 5'd0, 5'd0, 5'd16};
        // Two phases take random settings anywhere in the field range.
        for (int p = 5; p <= 6; p++) begin
            phase_k[p]   = CFG_DATA_W'($urandom_range(31));
            phase_cls[p] = CFG_DATA_W'($urandom_range(31));
        end

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr  <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. Reset settings are one neighbor and two
        // classes. A lone candidate at distance zero, then a query holding
        // only itself: no scan finds anything, so entry 0 still votes, and
        // its true class lies beyond the class range, so it must mismatch.
        set_idle_mode(IDLE_NONE);
        send_candidate('0, 4'd1, 4'd1, 1'b1);
        send_candidate(DIST_SELF, 4'd0, 4'd15, 1'b1);
        drain_results();

        // A write to an index with no register, then zero neighbors and
        // zero classes: nothing votes, class 0 wins with no votes.
        write_reg(REG_UNUSED, '1);
        load_settings(5'd0, 5'd0);
        send_candidate(DIST_W'(5), 4'd3, 4'd2, 1'b0);
        send_candidate(DIST_W'(1), 4'd2, 4'd0, 1'b1);
        drain_results();

        // Both settings at the top of their fields, clamped inside the block;
        // three candidates against sixteen scans, one of them the self mark.
        load_settings('1, '1);
        send_candidate(DIST_W'(7), 4'd15, 4'd0, 1'b0);
        send_candidate(DIST_SELF, 4'd4, 4'd0, 1'b0);
        send_candidate(DIST_W'(3), 4'd9, 4'd9, 1'b1);
        drain_results();

        // Equal distances (the earlier entry wins the scan), a class beyond
        // the range voting for class 0, and a tie won by the earlier class.
        load_settings(5'd3, 5'd4);
        send_candidate(DIST_W'(10), 4'd5, 4'd0, 1'b0);
        send_candidate(DIST_W'(10), 4'd1, 4'd0, 1'b0);
        send_candidate(DIST_W'(2), 4'd3, 4'd0, 1'b0);
        send_candidate(DIST_W'(4), 4'd2, 4'd0, 1'b1);
        drain_results();

        // Random phases, each with its own settings and stall mix.
        for (int p = 0; p < NUM_PHASES; p++) begin
            load_settings(phase_k[p], phase_cls[p]);
            set_idle_mode(idle_mode_t'(p % 4));
            phase_items = 0;
            // Open with a query that overflows the candidate store.
            if (p == 0) begin
                run_query(70);
                phase_items += 70;
            end
            while (phase_items < ITEMS_PER_PHASE) begin
                length = ($urandom_range(99) < 3) ? $urandom_range(80, 60)
                                                  : $urandom_range(12, 1);
                run_query(length);
                phase_items += length;
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("results never delivered", 0, sb.pending());

        if (sb.fail_count == 0)
            $display("knn_vote_classifier verification clean");
        else
            $display("knn_vote_classifier verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/knn_pkg.sv
rtl/knn_scan.sv
rtl/knn_vote_classifier.sv
verif/tb_knn_vote_classifier.sv
